### sv/assert_macros.svh
// Assertion macros shared by the RTL files of the slot pool manager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks a property at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("assertion failed");
// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### sv/osp_pkg.sv
// Types and constants shared by the slot pool manager files.
package osp_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int CMD_W         = 2;
    localparam int SLOT_W        = 4;
    localparam int ORDER_W       = 31;
    localparam int LEN_W         = 16;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 5;

    localparam logic [ORDER_W-1:0] TAG_LIMIT = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLAIM      = 2'd0,
        CMD_RET_FILLED = 2'd1,
        CMD_RET_EMPTY  = 2'd2,
        CMD_FETCH      = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NONE      = 2'd1,
        ST_INTEGRITY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        WR_INUSE = 2'd0,
        WR_FILL  = 2'd1,
        WR_CLEAR = 2'd2
    } t_wr_kind;

    // Search token travelling along the row of slot cells.
    typedef struct packed {
        logic               valid;
        logic               fetch;
        logic               found;
        logic [ORDER_W-1:0] ord;
        logic [LEN_W-1:0]   len;
    } t_scan;

    // Update broadcast to every cell; the addressed cell takes it.
    typedef struct packed {
        logic               en;
        t_wr_kind           kind;
        logic [ORDER_W-1:0] ord;
        logic [LEN_W-1:0]   len;
    } t_wr;

endpackage

### sv/osp_cmd_if.sv
// Command channel interface of the slot pool manager.
interface osp_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [osp_pkg::CMD_W-1:0]     cmd;
    logic [osp_pkg::SLOT_W-1:0]    slot_index;
    logic [osp_pkg::ORDER_W-1:0]   order_number;
    logic [osp_pkg::LEN_W-1:0]     data_length;

    modport source (output valid, cmd, slot_index, order_number, data_length, input ready);
    modport sink   (input valid, cmd, slot_index, order_number, data_length, output ready);
endinterface

### sv/osp_rsp_if.sv
// Response channel interface of the slot pool manager.
interface osp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [osp_pkg::STATUS_W-1:0]  status;
    logic [osp_pkg::SLOT_W-1:0]    granted_slot;
    logic [osp_pkg::ORDER_W-1:0]   fetched_order;
    logic [osp_pkg::LEN_W-1:0]     fetched_length;
    logic [osp_pkg::COUNT_W-1:0]   ready_count;

    modport source (output valid, status, granted_slot, fetched_order, fetched_length,
                    ready_count, input ready);
    modport sink   (input valid, status, granted_slot, fetched_order, fetched_length,
                    ready_count, output ready);
endinterface

### sv/ordered_slot_pool_manager.sv
// Slot pool manager top level: command decode, search chain of slot cells, response register.
// A return, or a fetch with no ready slot, goes from acceptance straight to the commit step; a
// claim or other fetch first waits while the token steps through every cell, one cell per cycle.
// One transaction is handled at a time; the next is taken the cycle after the previous one
// commits, and a held response delays that commit.
// Reset (synchronous, active low) empties every slot, the ready count and the response register.
`include "assert_macros.svh"

module ordered_slot_pool_manager #(
    parameter int SLOTS = osp_pkg::SLOTS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    osp_cmd_if.sink   i_cmd,
    osp_rsp_if.source o_rsp
);

    // Width of a slot index inside the pool, and a width wide enough for both
    // that index and the four-bit index carried on the channels.
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EXT_W = (IDX_W > osp_pkg::SLOT_W) ? IDX_W : osp_pkg::SLOT_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state                          r_state;
    t_state                          n_state;

    // The accepted command is held for the whole of its processing.
    osp_pkg::t_cmd                   r_cmd;
    logic [osp_pkg::SLOT_W-1:0]      r_idx;
    logic [osp_pkg::ORDER_W-1:0]     r_ord;
    logic [osp_pkg::LEN_W-1:0]       r_len;

    // Search result captured as the token leaves the last cell.
    osp_pkg::t_scan                  r_res;
    logic [IDX_W-1:0]                r_res_idx;

    logic [osp_pkg::COUNT_W-1:0]     r_count;
    logic [osp_pkg::COUNT_W-1:0]     n_count;

    logic                            r_out_valid;
    osp_pkg::t_status                r_status;
    logic [osp_pkg::SLOT_W-1:0]      r_granted;
    logic [osp_pkg::ORDER_W-1:0]     r_fo;
    logic [osp_pkg::LEN_W-1:0]       r_fl;
    osp_pkg::t_status                n_status;
    logic [osp_pkg::SLOT_W-1:0]      n_granted;
    logic [osp_pkg::ORDER_W-1:0]     n_fo;
    logic [osp_pkg::LEN_W-1:0]       n_fl;

    osp_pkg::t_scan                  chain     [SLOTS+1];
    logic [IDX_W-1:0]                chain_idx [SLOTS+1];
    logic [SLOTS:0]                  chain_vld;
    logic [SLOTS-1:0]                in_use;

    osp_pkg::t_wr                    wr;
    logic [IDX_W-1:0]                wr_idx;

    logic                            accept;
    logic                            launch;
    logic                            out_free;
    logic                            finish;
    logic [EXT_W-1:0]                ret_ext;
    logic [IDX_W-1:0]                ret_idx;
    logic                            ret_ok;
    logic [EXT_W-1:0]                res_ext;

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign finish   = (r_state == S_FINISH) && out_free;

    // Only claims and fetches with at least one ready slot need the search.
    assign launch = accept && ((osp_pkg::t_cmd'(i_cmd.cmd) == osp_pkg::CMD_CLAIM) ||
                    ((osp_pkg::t_cmd'(i_cmd.cmd) == osp_pkg::CMD_FETCH) && (r_count != '0)));

    always_comb begin
        chain[0].valid = launch;
        chain[0].fetch = (osp_pkg::t_cmd'(i_cmd.cmd) == osp_pkg::CMD_FETCH);
        chain[0].found = 1'b0;
        chain[0].ord   = osp_pkg::TAG_LIMIT;
        chain[0].len   = '0;
        chain_idx[0]   = '0;
    end

    // The row of slot cells. The search token moves one cell per cycle, so at
    // most one cell holds a live token at any time.
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        osp_cell #(
            .SLOT_ID (g),
            .IDX_W   (IDX_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_carry     (chain[g]),
            .i_carry_idx (chain_idx[g]),
            .o_carry     (chain[g+1]),
            .o_carry_idx (chain_idx[g+1]),
            .i_wr        (wr),
            .i_wr_idx    (wr_idx),
            .o_in_use    (in_use[g])
        );
    end

    for (genvar g = 0; g <= SLOTS; g++) begin : g_vld
        assign chain_vld[g] = chain[g].valid;
    end

    // A returned slot index beyond the pool is treated as a slot not in use.
    assign ret_ext = EXT_W'(r_idx);
    assign ret_idx = ret_ext[IDX_W-1:0];
    assign ret_ok  = (32'(r_idx) < SLOTS) && in_use[ret_idx];
    assign res_ext = EXT_W'(r_res_idx);

    // Commit step: decide the response and the single cell update.
    always_comb begin
        n_status  = osp_pkg::ST_NONE;
        n_granted = '0;
        n_fo      = '0;
        n_fl      = '0;
        n_count   = r_count;
        wr.en     = 1'b0;
        wr.kind   = osp_pkg::WR_INUSE;
        wr.ord    = r_ord;
        wr.len    = r_len;
        wr_idx    = r_res_idx;
        case (r_cmd)
            osp_pkg::CMD_CLAIM: begin
                if (r_res.found) begin
                    n_status  = osp_pkg::ST_OK;
                    n_granted = res_ext[osp_pkg::SLOT_W-1:0];
                    wr.en     = finish;
                end
            end
            osp_pkg::CMD_RET_FILLED, osp_pkg::CMD_RET_EMPTY: begin
                wr_idx = ret_idx;
                if (!ret_ok) begin
                    n_status = osp_pkg::ST_INTEGRITY;
                end else begin
                    n_status = osp_pkg::ST_OK;
                    wr.en    = finish;
                    if (r_cmd == osp_pkg::CMD_RET_FILLED) begin
                        wr.kind = osp_pkg::WR_FILL;
                        if (r_count != osp_pkg::COUNT_MAX) begin
                            n_count = r_count + osp_pkg::COUNT_W'(1);
                        end
                    end else begin
                        wr.kind = osp_pkg::WR_CLEAR;
                    end
                end
            end
            osp_pkg::CMD_FETCH: begin
                // A fetch consumes one ready count even when no slot qualifies.
                if (r_count != '0) begin
                    n_count = r_count - osp_pkg::COUNT_W'(1);
                    if (r_res.found) begin
                        n_status  = osp_pkg::ST_OK;
                        n_granted = res_ext[osp_pkg::SLOT_W-1:0];
                        n_fo      = r_res.ord;
                        n_fl      = r_res.len;
                        wr.en     = finish;
                    end
                end
            end
            default: begin
                n_status = osp_pkg::ST_NONE;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = launch ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                if (chain[SLOTS].valid) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= osp_pkg::t_cmd'(i_cmd.cmd);
            r_idx <= i_cmd.slot_index;
            r_ord <= i_cmd.order_number;
            r_len <= i_cmd.data_length;
        end
        if (chain[SLOTS].valid) begin
            r_res     <= chain[SLOTS];
            r_res_idx <= chain_idx[SLOTS];
        end
        if (finish) begin
            r_status  <= n_status;
            r_granted <= n_granted;
            r_fo      <= n_fo;
            r_fl      <= n_fl;
        end
    end

    assign i_cmd.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.granted_slot   = r_granted;
    assign o_rsp.fetched_order  = r_fo;
    assign o_rsp.fetched_length = r_fl;
    assign o_rsp.ready_count    = r_count;

    // The search token is never duplicated along the chain.
    `ASSERT_PROP(a_one_token, i_clk, i_rst_n, $onehot0(chain_vld))
    // The token leaves the last cell only while the controller waits for it.
    `ASSERT_NEVER(a_scan_end_state, i_clk, i_rst_n, chain[SLOTS].valid && (r_state != S_SCAN))
    // A response is produced only by the commit step.
    `ASSERT_PROP(a_rsp_from_finish, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(finish))
    // A fetch with ready slots always consumes one count.
    `ASSERT_PROP(a_fetch_consumes, i_clk, i_rst_n,
        (finish && (r_cmd == osp_pkg::CMD_FETCH) && (r_count != '0)) |=>
        (r_count == ($past(r_count) - osp_pkg::COUNT_W'(1))))

endmodule

### sv/osp_cell.sv
// One slot of the pool: its tag and length, and one stage of the search chain.
module osp_cell #(
    parameter int SLOT_ID = 0,
    parameter int IDX_W   = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  osp_pkg::t_scan       i_carry,
    input  logic [IDX_W-1:0]     i_carry_idx,
    output osp_pkg::t_scan       o_carry,
    output logic [IDX_W-1:0]     o_carry_idx,
    input  osp_pkg::t_wr         i_wr,
    input  logic [IDX_W-1:0]     i_wr_idx,
    output logic                 o_in_use
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT_ID);

    logic                          r_in_use;
    logic [osp_pkg::ORDER_W-1:0]   r_order;
    logic [osp_pkg::LEN_W-1:0]     r_len;
    osp_pkg::t_scan                r_carry;
    osp_pkg::t_scan                n_carry;
    logic [IDX_W-1:0]              r_carry_idx;
    logic [IDX_W-1:0]              n_carry_idx;
    logic                          is_empty;
    logic                          is_order;

    // A slot is empty when it is free with a zero tag; a free slot with a
    // non-zero tag holds an order.
    assign is_empty = !r_in_use && (r_order == '0);
    assign is_order = !r_in_use && (r_order != '0);

    always_comb begin
        n_carry     = i_carry;
        n_carry_idx = i_carry_idx;
        if (i_carry.valid) begin
            if (i_carry.fetch) begin
                if (is_order && (r_order < i_carry.ord)) begin
                    n_carry.found = 1'b1;
                    n_carry.ord   = r_order;
                    n_carry.len   = r_len;
                    n_carry_idx   = MY_IDX;
                end
            end else if (!i_carry.found && is_empty) begin
                n_carry.found = 1'b1;
                n_carry_idx   = MY_IDX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry.valid <= 1'b0;
        end else begin
            r_carry.valid <= n_carry.valid;
        end
        r_carry.fetch <= n_carry.fetch;
        r_carry.found <= n_carry.found;
        r_carry.ord   <= n_carry.ord;
        r_carry.len   <= n_carry.len;
        r_carry_idx   <= n_carry_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= 1'b0;
            r_order  <= '0;
        end else if (i_wr.en && (i_wr_idx == MY_IDX)) begin
            case (i_wr.kind)
                osp_pkg::WR_INUSE: begin
                    r_in_use <= 1'b1;
                end
                osp_pkg::WR_FILL: begin
                    r_in_use <= 1'b0;
                    r_order  <= i_wr.ord;
                end
                osp_pkg::WR_CLEAR: begin
                    r_in_use <= 1'b0;
                    r_order  <= '0;
                end
                default: begin
                    r_in_use <= r_in_use;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr_idx == MY_IDX) && (i_wr.kind == osp_pkg::WR_FILL)) begin
            r_len <= i_wr.len;
        end
    end

    assign o_carry     = r_carry;
    assign o_carry_idx = r_carry_idx;
    assign o_in_use    = r_in_use;

endmodule

### bench/testbench.sv
// Self-checking testbench for the ordered slot pool manager, with its own predictor and random traffic.
`timescale 1ns / 100ps

module testbench;
    import osp_pkg::*;

    localparam int POOL_SLOTS     = SLOTS_DEFAULT;
    localparam int RANDOM_ITEMS   = 1350;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = POOL_SLOTS + 10;

    // Slot tag encodings: empty, in use, and the first value that is never fetched.
    localparam logic [31:0] TAG_EMPTY   = 32'h0000_0000;
    localparam logic [31:0] TAG_IN_USE  = 32'hFFFF_FFFF;
    localparam logic [31:0] TAG_CEILING = {1'b0, TAG_LIMIT};

    typedef struct {
        t_cmd               cmd;
        logic [SLOT_W-1:0]  slot;
        logic [ORDER_W-1:0] ord;
        logic [LEN_W-1:0]   len;
    } pool_cmd_t;

    typedef struct {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [ORDER_W-1:0] ord;
        logic [LEN_W-1:0]   len;
        logic [COUNT_W-1:0] ready_total;
    } pool_rsp_t;

    // The scoreboard keeps its own picture of the pool. Every accepted command updates that
    // picture at once, so the stimulus can also ask it which slots are currently in use.
    class slot_pool_scoreboard;
        logic [31:0]        slot_tag [POOL_SLOTS];
        logic [LEN_W-1:0]   slot_len [POOL_SLOTS];
        logic [COUNT_W-1:0] ready_total;
        pool_rsp_t          expected_q [$];
        int                 last_grant;
        int                 errors;
        int                 checked;
        int                 peak_ready;
        int                 cmd_seen [4];
        int                 status_seen [3];

        function void clear();
            foreach (slot_tag[k]) begin
                slot_tag[k] = TAG_EMPTY;
                slot_len[k] = '0;
            end
            ready_total = '0;
            expected_q.delete();
            last_grant  = -1;
            errors      = 0;
            checked     = 0;
            peak_ready  = 0;
            foreach (cmd_seen[k]) cmd_seen[k] = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function int random_in_use();
            int busy [$];
            foreach (slot_tag[k]) begin
                if (slot_tag[k] == TAG_IN_USE) busy.push_back(k);
            end
            if (busy.size() == 0) return -1;
            return busy[$urandom_range(busy.size() - 1)];
        endfunction

        // Works out the response to one accepted command and moves the pool state on.
        function void note_command(pool_cmd_t c);
            pool_rsp_t   r;
            logic [31:0] lowest;
            int          best;
            r.status = ST_NONE;
            r.slot   = '0;
            r.ord    = '0;
            r.len    = '0;
            best     = -1;
            case (c.cmd)
                CMD_CLAIM: begin
                    for (int k = 0; k < POOL_SLOTS; k++) begin
                        if (best < 0 && slot_tag[k] == TAG_EMPTY) best = k;
                    end
                    if (best >= 0) begin
                        slot_tag[best] = TAG_IN_USE;
                        r.status       = ST_OK;
                        r.slot         = best[SLOT_W-1:0];
                    end
                end
                CMD_RET_FILLED, CMD_RET_EMPTY: begin
                    if (int'(c.slot) >= POOL_SLOTS || slot_tag[c.slot] != TAG_IN_USE) begin
                        r.status = ST_INTEGRITY;
                    end else begin
                        r.status = ST_OK;
                        if (c.cmd == CMD_RET_FILLED) begin
                            // An order of zero leaves the slot empty but still counts as ready.
                            slot_tag[c.slot] = {1'b0, c.ord};
                            slot_len[c.slot] = c.len;
                            if (ready_total != COUNT_MAX) ready_total++;
                        end else begin
                            slot_tag[c.slot] = TAG_EMPTY;
                        end
                    end
                end
                default: begin
                    // The ready count is consumed even when no slot qualifies.
                    if (ready_total != '0) begin
                        ready_total--;
                        lowest = TAG_CEILING;
                        for (int k = 0; k < POOL_SLOTS; k++) begin
                            if (slot_tag[k] != TAG_EMPTY && slot_tag[k] < lowest) begin
                                lowest = slot_tag[k];
                                best   = k;
                            end
                        end
                        if (best >= 0) begin
                            r.status       = ST_OK;
                            r.slot         = best[SLOT_W-1:0];
                            r.ord          = slot_tag[best][ORDER_W-1:0];
                            r.len          = slot_len[best];
                            slot_tag[best] = TAG_IN_USE;
                        end
                    end
                end
            endcase
            if (r.status != ST_OK || c.cmd == CMD_RET_FILLED || c.cmd == CMD_RET_EMPTY) best = -1;
            last_grant    = best;
            r.ready_total = ready_total;
            if (int'(ready_total) > peak_ready) peak_ready = ready_total;
            cmd_seen[c.cmd]++;
            status_seen[r.status]++;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t ns: %s", $time, what);
            errors++;
        endtask

        task check_response(pool_rsp_t got);
            pool_rsp_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("response with nothing outstanding, status %0d",
                                          got.status));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.status !== want.status)
                report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                          checked, got.status, want.status));
            if (got.slot !== want.slot)
                report_mismatch($sformatf("response %0d granted slot %0d, expected %0d",
                                          checked, got.slot, want.slot));
            if (got.ord !== want.ord)
                report_mismatch($sformatf("response %0d order 0x%0h, expected 0x%0h",
                                          checked, got.ord, want.ord));
            if (got.len !== want.len)
                report_mismatch($sformatf("response %0d length 0x%0h, expected 0x%0h",
                                          checked, got.len, want.len));
            if (got.ready_total !== want.ready_total)
                report_mismatch($sformatf("response %0d ready count %0d, expected %0d",
                                          checked, got.ready_total, want.ready_total));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    osp_cmd_if cmd_if ();
    osp_rsp_if rsp_if ();

    ordered_slot_pool_manager #(
        .SLOTS(POOL_SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_rsp  (rsp_if)
    );

    slot_pool_scoreboard sb;
    int items_sent;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Order numbers lean towards a handful of small values, so that ties between slots are
    // common, with some zeros, some values just under the fetch ceiling and the full range.
    function automatic logic [ORDER_W-1:0] random_order();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4) return '0;
        if (r < 40) return ORDER_W'($urandom_range(1, 12));
        if (r < 45) return ORDER_W'($urandom_range(32'h7FFF_FFF0, 32'h7FFF_FFFE));
        return ORDER_W'($urandom_range(1, 32'h7FFF_FFFE));
    endfunction

    function automatic logic [LEN_W-1:0] random_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return LEN_W'($urandom);
    endfunction

    // Offers one command transaction and returns once it has been accepted. Inputs change on
    // the falling edge; acceptance is judged on the rising edge. The sender idles in about a
    // fifth of the cycles, except over a stretch of items where it offers back to back.
    task automatic send_cmd(input t_cmd c, input int idx, input logic [ORDER_W-1:0] ord,
                            input logic [LEN_W-1:0] len);
        pool_cmd_t item;
        item.cmd  = c;
        item.slot = idx[SLOT_W-1:0];
        item.ord  = ord;
        item.len  = len;
        @(negedge i_clk);
        while (!(items_sent >= 1000 && items_sent < 1200) && $urandom_range(99) < 22) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid        = 1'b1;
        cmd_if.cmd          = item.cmd;
        cmd_if.slot_index   = item.slot;
        cmd_if.order_number = item.ord;
        cmd_if.data_length  = item.len;
        do @(posedge i_clk); while (!cmd_if.ready);
        sb.note_command(item);
        items_sent++;
    endtask

    // Stops offering commands until every outstanding response has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        cmd_if.valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    // One command of any kind; returns mostly go to a slot that is really in use.
    task automatic random_command();
        int unsigned r;
        int          s;
        r = $urandom_range(99);
        s = sb.random_in_use();
        if (s < 0 || $urandom_range(99) < 15) s = $urandom_range(POOL_SLOTS - 1);
        if (r < 25)      send_cmd(CMD_CLAIM, $urandom_range(15), random_order(), random_length());
        else if (r < 55) send_cmd(CMD_RET_FILLED, s, random_order(), random_length());
        else if (r < 70) send_cmd(CMD_RET_EMPTY, s, random_order(), random_length());
        else             send_cmd(CMD_FETCH, $urandom_range(15), random_order(), random_length());
    endtask

    // A well-formed round: claim a few slots, fill them, fetch as many, then hand the fetched
    // slots back, mostly empty and sometimes refilled.
    task automatic fill_and_drain();
        int grants [$];
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            send_cmd(CMD_CLAIM, $urandom_range(15), random_order(), random_length());
            if (sb.last_grant >= 0) grants.push_back(sb.last_grant);
        end
        foreach (grants[k]) send_cmd(CMD_RET_FILLED, grants[k], random_order(), random_length());
        grants.delete();
        repeat (n) begin
            send_cmd(CMD_FETCH, $urandom_range(15), random_order(), random_length());
            if (sb.last_grant >= 0) grants.push_back(sb.last_grant);
        end
        foreach (grants[k]) begin
            if ($urandom_range(3) != 0)
                send_cmd(CMD_RET_EMPTY, grants[k], random_order(), random_length());
            else
                send_cmd(CMD_RET_FILLED, grants[k], random_order(), random_length());
        end
    endtask

    // Claims a slot and returns it filled with order zero, over and over. The slot ends up
    // empty again each time while the ready count keeps climbing, so it can reach saturation.
    task automatic pump_ready_count();
        int n;
        int s;
        n = $urandom_range(16, 34);
        repeat (n) begin
            send_cmd(CMD_CLAIM, $urandom_range(15), random_order(), random_length());
            s = (sb.last_grant >= 0) ? sb.last_grant : int'($urandom_range(POOL_SLOTS - 1));
            send_cmd(CMD_RET_FILLED, s, '0, random_length());
        end
    endtask

    // Response side: ready is low in about a fifth of the cycles, high throughout one stretch,
    // and held low for a long spell once, so that the block backs up and refuses commands.
    initial begin : response_side
        pool_rsp_t got;
        int        accepted;
        int        hold_left;
        bit        held_once;
        accepted     = 0;
        hold_left    = 0;
        held_once    = 1'b0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_once && accepted >= 400) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                rsp_if.ready = 1'b0;
                hold_left--;
            end else if (accepted >= 900 && accepted < 1100) begin
                rsp_if.ready = 1'b1;
            end else begin
                rsp_if.ready = ($urandom_range(99) >= 22);
            end
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                got.status      = t_status'(rsp_if.status);
                got.slot        = rsp_if.granted_slot;
                got.ord         = rsp_if.fetched_order;
                got.len         = rsp_if.fetched_length;
                got.ready_total = rsp_if.ready_count;
                accepted++;
                sb.check_response(got);
            end
        end
    end

    // Ends the run if neither channel completes a transaction for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned p;
        bit          paused;
        sb = new;
        sb.clear();
        items_sent          = 0;
        paused              = 1'b0;
        cmd_if.valid        = 1'b0;
        cmd_if.cmd          = CMD_CLAIM;
        cmd_if.slot_index   = '0;
        cmd_if.order_number = '0;
        cmd_if.data_length  = '0;
        i_rst_n             = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed opening: errors on an empty pool, tie-breaking on equal orders, the
        // highest fetchable order, an order that can never be fetched, a fetch that consumes
        // the count without finding a slot, and extreme field values.
        send_cmd(CMD_FETCH, 0, '0, '0);
        send_cmd(CMD_RET_FILLED, 15, '1, '1);
        send_cmd(CMD_RET_EMPTY, 0, '0, '0);
        send_cmd(CMD_CLAIM, 0, '0, '0);
        send_cmd(CMD_CLAIM, 15, '1, '1);
        send_cmd(CMD_CLAIM, 0, '0, '0);
        send_cmd(CMD_RET_FILLED, 0, 31'h7FFF_FFFE, 16'hFFFF);
        send_cmd(CMD_RET_FILLED, 1, 31'd1, 16'h0000);
        send_cmd(CMD_RET_FILLED, 2, 31'd1, 16'h1234);
        send_cmd(CMD_FETCH, 0, '0, '0);
        send_cmd(CMD_FETCH, 0, '0, '0);
        send_cmd(CMD_FETCH, 0, '0, '0);
        send_cmd(CMD_RET_EMPTY, 1, '0, '0);
        send_cmd(CMD_RET_FILLED, 0, 31'h7FFF_FFFF, 16'h00FF);
        send_cmd(CMD_FETCH, 0, '0, '0);
        send_cmd(CMD_RET_FILLED, 2, '0, 16'hFF00);
        send_cmd(CMD_FETCH, 0, '0, '0);
        send_cmd(CMD_CLAIM, 0, '0, '0);
        send_cmd(CMD_CLAIM, 0, '0, '0);
        send_cmd(CMD_RET_EMPTY, 2, '0, '0);
        send_cmd(CMD_RET_FILLED, 1, 31'h5555_5555, 16'hAAAA);
        send_cmd(CMD_FETCH, 10, 31'h2AAA_AAAA, 16'h5555);
        send_cmd(CMD_RET_FILLED, 1, 31'h2AAA_AAAA, 16'h5555);
        send_cmd(CMD_FETCH, 5, 31'h5555_5555, 16'hAAAA);
        wait_drained();

        // Random part: mostly well-formed rounds and single commands, with an occasional run
        // that drives the ready count up towards saturation, and one pause to let everything drain.
        while (items_sent < 24 + RANDOM_ITEMS) begin
            if (!paused && items_sent >= 700) begin
                wait_drained();
                paused = 1'b1;
            end
            p = $urandom_range(99);
            if (p < 3)       pump_ready_count();
            else if (p < 25) fill_and_drain();
            else             random_command();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d transactions: %0d claims, %0d filled returns, %0d empty returns, %0d fetches.",
                 items_sent, sb.cmd_seen[CMD_CLAIM], sb.cmd_seen[CMD_RET_FILLED],
                 sb.cmd_seen[CMD_RET_EMPTY], sb.cmd_seen[CMD_FETCH]);
        $display("Outcomes: %0d ok, %0d no slot, %0d integrity; ready count peaked at %0d.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_NONE],
                 sb.status_seen[ST_INTEGRITY], sb.peak_ready);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d responses still outstanding",
                     sb.errors, sb.expected_q.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
